// ----- rtl/ccspc_pkg.sv -----
// Shared widths, register indexes, flag struct and latency helpers for the
// chroma segment pixel classifier. No dependencies.
`default_nettype none

package ccspc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PIX_W         = 8;
    localparam int SUM_W         = 10;
    localparam int COLOR_W       = 16;
    localparam int COLOR_FRAC    = 16;
    localparam int LIMIT_W       = 17;
    localparam int COS_W         = 16;
    localparam int CFG_DATA_W    = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int K_W           = 64;
    localparam int CHR_STEPS     = 4;
    localparam int CONE_STAGES   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS     = 3'd4;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic cos_neg;
        logic ref_zero;
    } cone_flags_t;

    // Stages of the chromaticity divider: quotient has f+1 bits.
    function automatic int chroma_stages(input int f);
        return (f + CHR_STEPS) / CHR_STEPS;
    endfunction

    function automatic int seg_latency(input int f);
        return chroma_stages(f) + f + 8;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ccspc_cfg_regs.sv -----
// Configuration registers and the values derived from them (aligned points,
// segment direction, squared lengths, cone product). Uses ccspc_pkg.
`default_nettype none

module ccspc_cfg_regs #(
    parameter int FRAC_BITS = ccspc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ccspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccspc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                              mode,
    output logic [ccspc_pkg::CFG_DATA_W-1:0]  color_a,
    output logic [2:0][FRAC_BITS-1:0]         a_al,
    output logic [2:0][FRAC_BITS+2:0]         v,
    output logic [2*FRAC_BITS+3:0]            m,
    output logic [2*FRAC_BITS+1:0]            lim_sq,
    output logic [ccspc_pkg::K_W-1:0]         k_cone,
    output ccspc_pkg::cone_flags_t            cone_flags
);
    import ccspc_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int AW  = F;
    localparam int BW  = F + 1;
    localparam int VW  = F + 3;
    localparam int MW  = 2 * F + 4;
    localparam int LW  = F + 1;
    localparam int LSW = 2 * F + 2;
    localparam int SHL = (F >= COLOR_FRAC) ? F - COLOR_FRAC : 0;
    localparam int SHR = (F < COLOR_FRAC) ? COLOR_FRAC - F : 0;
    localparam int NUDGE_RAW = ((1 << F) + 500) / 1000;
    localparam int NUDGE = (NUDGE_RAW < 1) ? 1 : NUDGE_RAW;

    function automatic logic [AW-1:0] align_color(input logic [COLOR_W-1:0] x);
        logic [COLOR_W+F-1:0] wide;
        wide = (COLOR_W + F)'(x);
        wide = (wide << SHL) >> SHR;
        return wide[AW-1:0];
    endfunction

    function automatic logic [LW-1:0] align_limit(input logic [LIMIT_W-1:0] x);
        logic [LIMIT_W+F-1:0] wide;
        wide = (LIMIT_W + F)'(x);
        wide = (wide << SHL) >> SHR;
        return wide[LW-1:0];
    endfunction

    logic                      mode_reg;
    logic [CFG_DATA_W-1:0]     color_a_reg;
    logic [CFG_DATA_W-1:0]     color_b_reg;
    logic [LIMIT_W-1:0]        dist_reg;
    logic signed [COS_W-1:0]   cos_reg;

    logic [2:0][AW-1:0]        a_al_reg, a_al_next;
    logic [2:0][BW-1:0]        b_al_reg, b_al_next;
    logic [2:0][VW-1:0]        v_reg, v_next;
    logic [2:0][MW-1:0]        vsq_reg, vsq_next;
    logic [MW-1:0]             m_reg, m_next;
    logic [LW-1:0]             lim_reg, lim_next;
    logic [LSW-1:0]            lim_sq_reg, lim_sq_next;
    logic [30:0]               cc_reg, cc_next;
    logic [2:0][31:0]          rsq_reg, rsq_next;
    logic [33:0]               rm_reg, rm_next;
    logic [62:0]               kl_reg, kl_next;
    logic [31:0]               kh_reg, kh_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic                      rm_zero_reg, rm_zero_next;

    logic [2:0][BW-1:0]        b_raw;
    logic                      same_pts;
    logic signed [2*VW-1:0]    vsq_full;
    logic signed [31:0]        cc_full;
    logic [32:0]               kh_full;
    logic [COLOR_W-1:0]        ref_ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            color_a_reg <= '0;
            color_b_reg <= '0;
            dist_reg    <= '0;
            cos_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    mode_reg    <= cfg_data[0];
                CFG_COLOR_A: color_a_reg <= cfg_data;
                CFG_COLOR_B: color_b_reg <= cfg_data;
                CFG_DIST:    dist_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_COS:     cos_reg     <= $signed(cfg_data[COS_W-1:0]);
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        same_pts = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            a_al_next[i] = align_color(color_a_reg[CFG_DATA_W-1-COLOR_W*i -: COLOR_W]);
            b_raw[i]     = BW'(align_color(color_b_reg[CFG_DATA_W-1-COLOR_W*i -: COLOR_W]));
            if (BW'(a_al_next[i]) != b_raw[i])
            begin
                same_pts = 1'b0;
            end
        end
        b_al_next = b_raw;
        // Coincident points: nudge red so the segment has a length.
        if (same_pts)
        begin
            b_al_next[0] = b_raw[0] + BW'(NUDGE);
        end

        for (int i = 0; i < 3; i++)
        begin
            v_next[i]   = VW'(b_al_reg[i]) - VW'(a_al_reg[i]);
            vsq_full    = $signed(v_reg[i]) * $signed(v_reg[i]);
            vsq_next[i] = vsq_full[MW-1:0];
            ref_ch      = color_a_reg[CFG_DATA_W-1-COLOR_W*i -: COLOR_W];
            rsq_next[i] = ref_ch * ref_ch;
        end
        m_next      = vsq_reg[0] + vsq_reg[1] + vsq_reg[2];

        lim_next    = align_limit(dist_reg);
        lim_sq_next = lim_reg * lim_reg;

        cc_full      = cos_reg * cos_reg;
        cc_next      = cc_full[30:0];
        rm_next      = 34'(rsq_reg[0]) + 34'(rsq_reg[1]) + 34'(rsq_reg[2]);
        kl_next      = cc_reg * rm_reg[31:0];
        kh_full      = cc_reg * rm_reg[33:32];
        kh_next      = kh_full[31:0];
        k_next       = {kh_reg, 32'b0} + K_W'(kl_reg);
        rm_zero_next = (rm_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_al_reg    <= '0;
            b_al_reg    <= '0;
            b_al_reg[0] <= BW'(NUDGE);
            v_reg       <= '0;
            v_reg[0]    <= VW'(NUDGE);
            vsq_reg     <= '0;
            vsq_reg[0]  <= MW'(NUDGE * NUDGE);
            m_reg       <= MW'(NUDGE * NUDGE);
            lim_reg     <= '0;
            lim_sq_reg  <= '0;
            cc_reg      <= '0;
            rsq_reg     <= '0;
            rm_reg      <= '0;
            kl_reg      <= '0;
            kh_reg      <= '0;
            k_reg       <= '0;
            rm_zero_reg <= 1'b1;
        end
        else
        begin
            a_al_reg    <= a_al_next;
            b_al_reg    <= b_al_next;
            v_reg       <= v_next;
            vsq_reg     <= vsq_next;
            m_reg       <= m_next;
            lim_reg     <= lim_next;
            lim_sq_reg  <= lim_sq_next;
            cc_reg      <= cc_next;
            rsq_reg     <= rsq_next;
            rm_reg      <= rm_next;
            kl_reg      <= kl_next;
            kh_reg      <= kh_next;
            k_reg       <= k_next;
            rm_zero_reg <= rm_zero_next;
        end
    end

    assign mode                = mode_reg;
    assign color_a             = color_a_reg;
    assign a_al                = a_al_reg;
    assign v                   = v_reg;
    assign m                   = m_reg;
    assign lim_sq              = lim_sq_reg;
    assign k_cone              = k_reg;
    assign cone_flags.cos_neg  = cos_reg[COS_W-1];
    assign cone_flags.ref_zero = rm_zero_reg;

endmodule

`default_nettype wire

// ----- rtl/ccspc_seg_path.sv -----
// Segment mode pipeline: chromaticity divider, projection, second divider,
// error energy and threshold. Uses ccspc_pkg.
`default_nettype none

module ccspc_seg_path #(
    parameter int FRAC_BITS = ccspc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [2:0][ccspc_pkg::PIX_W-1:0]     px,
    input  logic [2:0][FRAC_BITS-1:0]            a_al,
    input  logic [2:0][FRAC_BITS+2:0]            v,
    input  logic [2*FRAC_BITS+3:0]               m,
    input  logic [2*FRAC_BITS+1:0]               lim_sq,
    output logic                                 seg_mark
);
    import ccspc_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int ND  = chroma_stages(F);
    localparam int UW  = F + 2;
    localparam int PW  = 2 * F + 5;
    localparam int TW  = 2 * F + 7;
    localparam int MW  = 2 * F + 4;
    localparam int EW  = F + 4;
    localparam int SW  = 2 * F + 8;
    localparam int DW  = 2 * F + 10;

    // input stage
    logic [2:0][PIX_W-1:0]   px_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    zero_reg;

    // chromaticity divider
    logic [2:0][SUM_W-1:0]   crem_reg  [ND];
    logic [2:0][SUM_W-1:0]   crem_next [ND];
    logic [2:0][F:0]         cq_reg    [ND];
    logic [2:0][F:0]         cq_next   [ND];
    logic [SUM_W-1:0]        csum_reg  [ND];
    logic [SUM_W-1:0]        csum_next [ND];
    logic                    cz_reg    [ND];
    logic                    cz_next   [ND];

    // projection
    logic signed [UW-1:0]    u_reg [3];
    logic                    uz_reg;
    logic signed [PW-1:0]    p_reg [3];
    logic signed [UW-1:0]    pu_reg [3];
    logic                    pz_reg;
    logic signed [TW-1:0]    t_reg;
    logic                    tle_reg, tge_reg, tz_reg;
    logic signed [UW-1:0]    tu_reg [3];

    // parameter divider, one quotient bit per stage
    logic [MW-1:0]           drem_reg  [F];
    logic [MW-1:0]           drem_next [F];
    logic [F-1:0]            dq_reg    [F];
    logic [F-1:0]            dq_next   [F];
    logic signed [UW-1:0]    du_reg    [F][3];
    logic                    dle_reg   [F];
    logic                    dge_reg   [F];
    logic                    dz_reg    [F];

    // error energy
    logic signed [PW-1:0]    vd_reg [3];
    logic signed [UW-1:0]    vu_reg [3];
    logic                    vz_reg;
    logic signed [EW-1:0]    e_reg [3];
    logic                    ez_reg;
    logic signed [SW-1:0]    sq_reg [3];
    logic                    sz_reg;
    logic                    mark_reg;

    logic [SUM_W-1:0]        rem_w, sum_w;
    logic [F:0]              q_w;
    logic [SUM_W:0]          trial_w;
    logic                    qbit;
    logic                    dqbit;
    logic [MW:0]             dtrial;
    logic [MW-1:0]           drem_w;
    logic [F-1:0]            dq_w;
    logic [F:0]              d_w;
    logic signed [TW-1:0]    t_w;
    logic [DW-1:0]           dd_w;
    logic signed [PW-1:0]    vd_w [3];
    logic signed [PW-1:0]    p_w  [3];
    logic signed [SW-1:0]    sq_w [3];
    logic signed [EW-1:0]    e_w  [3];
    logic signed [UW-1:0]    u_w  [3];

    // chromaticity: restoring division of px*2^F by the channel sum
    always_comb
    begin
        for (int k = 0; k < ND; k++)
        begin
            if (k == 0)
            begin
                sum_w        = sum_reg;
                cz_next[k]   = zero_reg;
            end
            else
            begin
                sum_w        = csum_reg[k-1];
                cz_next[k]   = cz_reg[k-1];
            end
            csum_next[k] = sum_w;
            for (int ch = 0; ch < 3; ch++)
            begin
                if (k == 0)
                begin
                    rem_w = SUM_W'(px_reg[ch]);
                    q_w   = '0;
                end
                else
                begin
                    rem_w = crem_reg[k-1][ch];
                    q_w   = cq_reg[k-1][ch];
                end
                for (int i = 0; i < CHR_STEPS; i++)
                begin
                    if (k * CHR_STEPS + i <= F)
                    begin
                        if (k * CHR_STEPS + i == 0)
                        begin
                            trial_w = {1'b0, rem_w};
                        end
                        else
                        begin
                            trial_w = {rem_w, 1'b0};
                        end
                        qbit = (trial_w >= {1'b0, sum_w});
                        if (qbit)
                        begin
                            trial_w = trial_w - {1'b0, sum_w};
                        end
                        rem_w = trial_w[SUM_W-1:0];
                        q_w   = {q_w[F-1:0], qbit};
                    end
                end
                crem_next[k][ch] = rem_w;
                cq_next[k][ch]   = q_w;
            end
        end
    end

    // parameter: restoring division of t*2^F by m
    always_comb
    begin
        for (int j = 0; j < F; j++)
        begin
            if (j == 0)
            begin
                drem_w = t_reg[MW-1:0];
                dq_w   = '0;
            end
            else
            begin
                drem_w = drem_reg[j-1];
                dq_w   = dq_reg[j-1];
            end
            dtrial = {drem_w, 1'b0};
            dqbit  = (dtrial >= {1'b0, m});
            if (dqbit)
            begin
                dtrial = dtrial - {1'b0, m};
            end
            drem_next[j] = dtrial[MW-1:0];
            dq_next[j]   = {dq_w[F-2:0], dqbit};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_w[i]  = UW'(cq_reg[ND-1][i]) - UW'(a_al[i]);
            p_w[i]  = u_reg[i] * $signed(v[i]);
        end
        t_w = TW'(p_reg[0]) + TW'(p_reg[1]) + TW'(p_reg[2]);

        if (dle_reg[F-1])
        begin
            d_w = '0;
        end
        else if (dge_reg[F-1])
        begin
            d_w = (F + 1)'(1) << F;
        end
        else
        begin
            d_w = {1'b0, dq_reg[F-1]};
        end
        for (int i = 0; i < 3; i++)
        begin
            vd_w[i] = $signed(v[i]) * $signed({1'b0, d_w});
            e_w[i]  = EW'(vu_reg[i]) - EW'(vd_reg[i] >>> F);
            sq_w[i] = e_reg[i] * e_reg[i];
        end
        dd_w = DW'(sq_reg[0]) + DW'(sq_reg[1]) + DW'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px;
            sum_reg  <= SUM_W'(px[0]) + SUM_W'(px[1]) + SUM_W'(px[2]);
            zero_reg <= (px == '0);

            for (int k = 0; k < ND; k++)
            begin
                crem_reg[k] <= crem_next[k];
                cq_reg[k]   <= cq_next[k];
                csum_reg[k] <= csum_next[k];
                cz_reg[k]   <= cz_next[k];
            end

            for (int i = 0; i < 3; i++)
            begin
                u_reg[i]  <= u_w[i];
                p_reg[i]  <= p_w[i];
                pu_reg[i] <= u_reg[i];
                tu_reg[i] <= pu_reg[i];
            end
            uz_reg  <= cz_reg[ND-1];
            pz_reg  <= uz_reg;
            t_reg   <= t_w;
            tle_reg <= (t_w <= 0);
            tge_reg <= (t_w >= $signed({3'b000, m}));
            tz_reg  <= pz_reg;

            for (int j = 0; j < F; j++)
            begin
                drem_reg[j] <= drem_next[j];
                dq_reg[j]   <= dq_next[j];
                if (j == 0)
                begin
                    du_reg[j]  <= tu_reg;
                    dle_reg[j] <= tle_reg;
                    dge_reg[j] <= tge_reg;
                    dz_reg[j]  <= tz_reg;
                end
                else
                begin
                    du_reg[j]  <= du_reg[j-1];
                    dle_reg[j] <= dle_reg[j-1];
                    dge_reg[j] <= dge_reg[j-1];
                    dz_reg[j]  <= dz_reg[j-1];
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                vd_reg[i] <= vd_w[i];
                vu_reg[i] <= du_reg[F-1][i];
                e_reg[i]  <= e_w[i];
                sq_reg[i] <= sq_w[i];
            end
            vz_reg   <= dz_reg[F-1];
            ez_reg   <= vz_reg;
            sz_reg   <= ez_reg;
            mark_reg <= !sz_reg && (dd_w < DW'(lim_sq));
        end
    end

    assign seg_mark = mark_reg;

endmodule

`default_nettype wire

// ----- rtl/ccspc_cone_path.sv -----
// Cone mode pipeline: exact integer cosine test against the reference color,
// delayed to line up with the segment path. Uses ccspc_pkg.
`default_nettype none

module ccspc_cone_path #(
    parameter int FRAC_BITS = ccspc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [2:0][ccspc_pkg::PIX_W-1:0]     px,
    input  logic [ccspc_pkg::CFG_DATA_W-1:0]     color_a,
    input  logic [ccspc_pkg::K_W-1:0]            k_cone,
    input  ccspc_pkg::cone_flags_t               cone_flags,
    output logic                                 cone_mark
);
    import ccspc_pkg::*;

    localparam int DLY = seg_latency(FRAC_BITS) - CONE_STAGES;

    logic [2:0][PIX_W-1:0]   px_reg;
    logic [2:0][23:0]        pr_reg;
    logic [2:0][15:0]        pp_reg;
    logic [25:0]             dot_reg;
    logic [17:0]             pm_reg;
    logic [51:0]             dsq_reg, dsq4_reg, dsq5_reg;
    logic [17:0]             pm3_reg;
    logic                    pnz4_reg, pnz5_reg;
    logic [3:0][33:0]        kp_reg;
    logic [50:0]             rlo_reg, rhi_reg;
    logic                    mark_reg;
    logic [DLY-1:0]          dly_reg;

    logic [83:0]             rhs_w;
    logic [81:0]             lhs_w;

    always_comb
    begin
        rhs_w = 84'(rlo_reg) + {1'b0, rhi_reg, 32'b0};
        lhs_w = {dsq5_reg, 30'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px;
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= px_reg[i] * color_a[CFG_DATA_W-1-COLOR_W*i -: COLOR_W];
                pp_reg[i] <= px_reg[i] * px_reg[i];
            end
            dot_reg  <= 26'(pr_reg[0]) + 26'(pr_reg[1]) + 26'(pr_reg[2]);
            pm_reg   <= 18'(pp_reg[0]) + 18'(pp_reg[1]) + 18'(pp_reg[2]);
            dsq_reg  <= dot_reg * dot_reg;
            pm3_reg  <= pm_reg;
            for (int j = 0; j < 4; j++)
            begin
                kp_reg[j] <= k_cone[16*j +: 16] * pm3_reg;
            end
            dsq4_reg <= dsq_reg;
            pnz4_reg <= (pm3_reg != '0);
            rlo_reg  <= 51'(kp_reg[0]) + {1'b0, kp_reg[1], 16'b0};
            rhi_reg  <= 51'(kp_reg[2]) + {1'b0, kp_reg[3], 16'b0};
            dsq5_reg <= dsq4_reg;
            pnz5_reg <= pnz4_reg;
            mark_reg <= pnz5_reg && !cone_flags.ref_zero
                        && (cone_flags.cos_neg || (84'(lhs_w) > rhs_w));
            dly_reg  <= {dly_reg[DLY-2:0], mark_reg};
        end
    end

    assign cone_mark = dly_reg[DLY-1];

endmodule

`default_nettype wire

// ----- rtl/ccspc_out_buf.sv -----
// Output register with one skid entry; produces the pipeline advance.
// Standalone, no package dependencies.
`default_nettype none

module ccspc_out_buf (
    input  logic clk,
    input  logic rst_n,
    input  logic pipe_valid,
    input  logic pipe_mark,
    input  logic mask_ready,
    output logic mask_valid,
    output logic mask_bit,
    output logic adv
);
    logic out_v_reg, out_bit_reg;
    logic skid_v_reg, skid_bit_reg;
    logic pv;

    assign adv = !skid_v_reg;
    assign pv  = pipe_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg    <= 1'b0;
            out_bit_reg  <= 1'b0;
            skid_v_reg   <= 1'b0;
            skid_bit_reg <= 1'b0;
        end
        else if (out_v_reg && mask_ready)
        begin
            if (skid_v_reg)
            begin
                out_bit_reg <= skid_bit_reg;
                skid_v_reg  <= 1'b0;
            end
            else
            begin
                out_v_reg   <= pv;
                out_bit_reg <= pipe_mark;
            end
        end
        else if (!out_v_reg)
        begin
            out_v_reg   <= pv;
            out_bit_reg <= pipe_mark;
        end
        else if (pv)
        begin
            skid_v_reg   <= 1'b1;
            skid_bit_reg <= pipe_mark;
        end
    end

    assign mask_valid = out_v_reg;
    assign mask_bit   = out_bit_reg;

`ifndef SYNTHESIS
    a_skid_under_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid beat held without an output beat");
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !mask_ready))
        else $error("skid filled while output was free");
    a_drop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_v_reg) |-> $past(mask_ready))
        else $error("output beat dropped without being taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/chroma_segment_pixel_classifier.sv -----
// Pixel-beat-to-mask-beat delay is set by the two restoring dividers, one bit per step.
// Throughput: one pixel per clock; the whole pipe holds only while the skid is full.
// Reset: asynchronous, active low; configuration registers clear to zero,
// in-flight beats drop.
// Config-derived terms are registered, so they lag a write before they settle.
`default_nettype none

module chroma_segment_pixel_classifier #(
    parameter int FRAC_BITS = ccspc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  ccspc_pkg::pix_t                   pixel_red,
    input  ccspc_pkg::pix_t                   pixel_green,
    input  ccspc_pkg::pix_t                   pixel_blue,
    output logic                              mask_valid,
    input  logic                              mask_ready,
    output logic                              mask_bit,
    input  logic                              cfg_we,
    input  logic [ccspc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccspc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ccspc_pkg::*;

    localparam int LAT = seg_latency(FRAC_BITS);

    logic                         adv;
    logic [LAT-1:0]               vld_reg;
    logic [2:0][PIX_W-1:0]        px;
    logic                         mode;
    logic [CFG_DATA_W-1:0]        color_a;
    logic [2:0][FRAC_BITS-1:0]    a_al;
    logic [2:0][FRAC_BITS+2:0]    v;
    logic [2*FRAC_BITS+3:0]       m;
    logic [2*FRAC_BITS+1:0]       lim_sq;
    logic [K_W-1:0]               k_cone;
    cone_flags_t                  cone_flags;
    logic                         seg_mark, cone_mark;

    assign px[0] = pixel_red;
    assign px[1] = pixel_green;
    assign px[2] = pixel_blue;

    // Accept while the skid entry is free, even with a mask beat waiting.
    assign pixel_ready = adv;

    ccspc_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mode       (mode),
        .color_a    (color_a),
        .a_al       (a_al),
        .v          (v),
        .m          (m),
        .lim_sq     (lim_sq),
        .k_cone     (k_cone),
        .cone_flags (cone_flags)
    );

    ccspc_seg_path #(.FRAC_BITS(FRAC_BITS)) u_seg (
        .clk      (clk),
        .en       (adv),
        .px       (px),
        .a_al     (a_al),
        .v        (v),
        .m        (m),
        .lim_sq   (lim_sq),
        .seg_mark (seg_mark)
    );

    ccspc_cone_path #(.FRAC_BITS(FRAC_BITS)) u_cone (
        .clk        (clk),
        .en         (adv),
        .px         (px),
        .color_a    (color_a),
        .k_cone     (k_cone),
        .cone_flags (cone_flags),
        .cone_mark  (cone_mark)
    );

    // Valid bits advance with the datapath; a bubble is just a zero bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], pixel_valid};
        end
    end

    // Both paths run on every pixel; the mode picks the answer at the end.
    ccspc_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (vld_reg[LAT-1]),
        .pipe_mark  (mode ? cone_mark : seg_mark),
        .mask_ready (mask_ready),
        .mask_valid (mask_valid),
        .mask_bit   (mask_bit),
        .adv        (adv)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for chroma_segment_pixel_classifier: segment and cone modes,
// random traffic with back-pressure. Depends on ccspc_pkg and the classifier RTL.
`default_nettype none

module tb;
    import ccspc_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int PIPE_WAIT = 48;        // a little over the pixel-to-mask path
    localparam int CYCLE_CAP = 400000;
    localparam int REPORT_N  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    pix_t                  pixel_red, pixel_green, pixel_blue;
    logic                  mask_valid;
    logic                  mask_ready;
    logic                  mask_bit;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the configuration registers.
    logic                  sh_mode;
    logic [47:0]           sh_color_a, sh_color_b;
    logic [LIMIT_W-1:0]    sh_dist;
    logic signed [COS_W-1:0] sh_cos;

    logic mask_q[$];         // expected mask bits, oldest first
    int   mismatches;
    int   cycles;
    int   hold_left;
    bit   hold_req;
    int   stall_style;

    always #6 clk = ~clk;

    chroma_segment_pixel_classifier u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .mask_valid  (mask_valid),
        .mask_ready  (mask_ready),
        .mask_bit    (mask_bit),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Segment mode: project the pixel chromaticity onto segment A..B, clamp the
    // parameter, compare squared distance to the closest point with limit^2.
    function automatic logic segment_match(input pix_t r, input pix_t g, input pix_t b);
        longint px[3], a[3], bb[3], u[3], v[3];
        longint sum, t, m, d, e, dd, lim;
        begin
            px[0] = r; px[1] = g; px[2] = b;
            sum = px[0] + px[1] + px[2];
            t = 0; m = 0; dd = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i]  = longint'(sh_color_a[32 - 16*i +: 16]) <<< (FRAC - COLOR_FRAC);
                bb[i] = longint'(sh_color_b[32 - 16*i +: 16]) <<< (FRAC - COLOR_FRAC);
            end
            // identical endpoints: nudge red of point B by 0.001
            if (a[0] == bb[0] && a[1] == bb[1] && a[2] == bb[2])
                bb[0] += ((64'd1 << FRAC) + 500) / 1000;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = ((px[i] << FRAC) / sum) - a[i];
                v[i] = bb[i] - a[i];
                t += u[i] * v[i];
                m += v[i] * v[i];
            end
            if (t <= 0)
                d = 0;
            else if (t >= m)
                d = longint'(1) << FRAC;
            else
                d = (t << FRAC) / m;
            for (int i = 0; i < 3; i++)
            begin
                e = u[i] - ((v[i] * d) >>> FRAC);
                dd += e * e;
            end
            lim = longint'(sh_dist) <<< (FRAC - COLOR_FRAC);
            return dd < lim * lim;
        end
    endfunction

    // Cone mode: cos^2 test done exactly, dot^2 * 2^30 > cos^2 * |p|^2 * |ref|^2.
    function automatic logic cone_match(input pix_t r, input pix_t g, input pix_t b);
        logic [127:0] dot, pm, rm, cc, lhs, rhs;
        logic [127:0] px[3], rf[3];
        begin
            px[0] = r; px[1] = g; px[2] = b;
            dot = 0; pm = 0; rm = 0;
            for (int i = 0; i < 3; i++)
            begin
                rf[i] = sh_color_a[32 - 16*i +: 16];
                dot += px[i] * rf[i];
                pm  += px[i] * px[i];
                rm  += rf[i] * rf[i];
            end
            if (pm == 0 || rm == 0)
                return 1'b0;
            if (sh_cos < 0)
                return 1'b1;
            cc  = 128'(sh_cos) * 128'(sh_cos);
            lhs = (dot * dot) << 30;
            rhs = cc * pm * rm;
            return lhs > rhs;
        end
    endfunction

    function automatic logic classify_pixel(input pix_t r, input pix_t g, input pix_t b);
        if (r + g + b == 0)
            return 1'b0;
        return sh_mode ? cone_match(r, g, b) : segment_match(r, g, b);
    endfunction

    // Check every mask beat against the oldest expectation.
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && mask_valid && mask_ready)
        begin
            if (mask_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_N)
                    $display("unexpected mask beat: got %0b", mask_bit);
            end
            else
            begin
                want = mask_q.pop_front();
                if (mask_bit !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_N)
                        $display("mask mismatch: expected %0b got %0b", want, mask_bit);
                end
            end
        end
    end

    // Receiver: honor a long hold-off on request, otherwise stall per the current style.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            mask_ready <= 1'b0;
        end
        else
        begin
            case (stall_style)
                0:       mask_ready <= 1'b1;
                1:       mask_ready <= ($urandom_range(0, 1) == 0);
                2:       mask_ready <= ($urandom_range(0, 7) == 0);
                default: mask_ready <= ((cycles % 16) < 11);
            endcase
        end
    end

    // Watchdog: bail out if the run hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[chroma_segment_pixel_classifier] ERROR");
            $finish;
        end
    end

    // Offer one pixel beat and hold it until accepted; record the expected mask.
    task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
        @(negedge clk);
        pixel_valid = 1'b1;
        pixel_red   = r;
        pixel_green = g;
        pixel_blue  = b;
        do
            @(posedge clk);
        while (!pixel_ready);
        mask_q = {mask_q, classify_pixel(r, g, b)};
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        pixel_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait until every expected mask has come, then let the pipe empty.
    task automatic drain_results();
        idle_sender(0);
        while (mask_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MODE:    sh_mode    = val[0];
            CFG_COLOR_A: sh_color_a = val[47:0];
            CFG_COLOR_B: sh_color_b = val[47:0];
            CFG_DIST:    sh_dist    = val[LIMIT_W-1:0];
            CFG_COS:     sh_cos     = val[COS_W-1:0];
            default:     ;
        endcase
    endtask

    // Let config-derived terms settle before pixels flow.
    task automatic settle_cfg();
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Chromaticity point of a random color, packed as three Q0.16 fields.
    function automatic logic [47:0] rand_chroma();
        int r, g, b, s;
        begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            s = r + g + b;
            if (s == 0)
                return 48'd0;
            return {16'((r << 16) / s), 16'((g << 16) / s), 16'((b << 16) / s)};
        end
    endfunction

    // Random burst of pixels with random gaps; biased toward extremes at times.
    task automatic random_burst(input int n);
        int left;
        pix_t r, g, b;
        begin
            left = n;
            while (left > 0)
            begin
                for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--)
                begin
                    r = $urandom_range(0, 9) == 0 ? pix_t'(0) : pix_t'($urandom);
                    g = $urandom_range(0, 9) == 0 ? pix_t'(255) : pix_t'($urandom);
                    b = pix_t'($urandom);
                    send_pixel(r, g, b);
                    left--;
                end
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(0, 6));
            end
        end
    endtask

    task automatic send_corner_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);         // black: never marked
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd10);
    endtask

    // Segment mode: identical endpoints, extremes of the distance limit.
    task automatic test_segment_directed();
        stall_style = 0;
        write_reg(CFG_MODE, 48'd0);
        write_reg(CFG_COLOR_A, {16'd21845, 16'd21845, 16'd21845});
        write_reg(CFG_COLOR_B, {16'd21845, 16'd21845, 16'd21845});
        write_reg(CFG_DIST, 48'd6000);
        settle_cfg();
        send_corner_pixels();
        drain_results();
        write_reg(CFG_COLOR_A, 48'd0);
        write_reg(CFG_COLOR_B, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_DIST, 48'h1FFFF);
        write_reg(CFG_UNUSED_LO, rand48());   // ignored index
        settle_cfg();
        send_corner_pixels();
        drain_results();
        write_reg(CFG_DIST, 48'd0);           // nothing is closer than zero
        settle_cfg();
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd17, 8'd99, 8'd3);
        drain_results();
    endtask

    // Cone mode: zero reference, negative, zero and maximum cosine limits.
    task automatic test_cone_directed();
        stall_style = 1;
        write_reg(CFG_MODE, 48'd1);
        write_reg(CFG_COLOR_A, 48'd0);
        write_reg(CFG_COS, 48'h8000);
        settle_cfg();
        send_pixel(8'd255, 8'd255, 8'd255);   // zero reference: never marked
        drain_results();
        write_reg(CFG_COLOR_A, 48'hFFFF_FFFF_FFFF);
        settle_cfg();
        send_corner_pixels();
        drain_results();
        write_reg(CFG_COS, 48'd0);
        settle_cfg();
        send_corner_pixels();
        drain_results();
        write_reg(CFG_COS, 48'h7FFF);
        write_reg(CFG_UNUSED_HI, rand48());
        settle_cfg();
        send_corner_pixels();
        drain_results();
    endtask

    // Random phases: reprogram every register, then push a burst of pixels.
    task automatic test_random_phases();
        for (int phase = 0; phase < 12; phase++)
        begin
            stall_style = phase % 4;
            write_reg(CFG_MODE, 48'(phase % 2) | (rand48() & 48'hFFFF_FFFF_FFFE));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_COLOR_A, rand48());
                write_reg(CFG_COLOR_B, rand48());
            end
            else
            begin
                write_reg(CFG_COLOR_A, rand_chroma());
                write_reg(CFG_COLOR_B, rand_chroma());
            end
            write_reg(CFG_DIST, $urandom_range(0, 3) == 0 ? rand48() : 48'($urandom_range(0, 20000)));
            write_reg(CFG_COS, $urandom_range(0, 3) == 0 ? rand48()
                                                          : 48'($urandom_range(20000, 32767)));
            settle_cfg();
            random_burst(50);
            drain_results();
        end
    endtask

    // Long receiver hold-off while pixels keep coming, then a burst against a periodic stall.
    task automatic test_backpressure();
        write_reg(CFG_MODE, 48'd1);
        write_reg(CFG_COLOR_A, rand48());
        write_reg(CFG_COS, 48'd28000);
        settle_cfg();
        stall_style = 0;
        @(posedge clk);
        hold_req = 1'b1;
        for (int k = 0; k < 90; k++)
            send_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
        drain_results();
        stall_style = 3;
        random_burst(40);
        drain_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel_red   = '0;
        pixel_green = '0;
        pixel_blue  = '0;
        mask_ready  = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        sh_mode     = 1'b0;
        sh_color_a  = '0;
        sh_color_b  = '0;
        sh_dist     = '0;
        sh_cos      = '0;
        mismatches  = 0;
        cycles      = 0;
        hold_left   = 0;
        hold_req    = 1'b0;
        stall_style = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        test_segment_directed();
        test_cone_directed();
        test_random_phases();
        test_backpressure();

        if (mismatches == 0 && mask_q.size() == 0)
            $display("[chroma_segment_pixel_classifier] OK");
        else
            $display("[chroma_segment_pixel_classifier] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- chroma_segment_pixel_classifier.f -----
rtl/ccspc_pkg.sv
rtl/ccspc_cfg_regs.sv
rtl/ccspc_seg_path.sv
rtl/ccspc_cone_path.sv
rtl/ccspc_out_buf.sv
rtl/chroma_segment_pixel_classifier.sv
tb/tb.sv
